// ===== sv/eia3_mac_accumulator_core_macros.svh =====
// ----------------------------------------------------------------------------
// eia3 mac accumulator assertion macros
// shared property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef EIA3_MAC_ACCUMULATOR_CORE_MACROS_SVH
`define EIA3_MAC_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EIA3_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define EIA3_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/eia3mac_pkg.sv =====
// ----------------------------------------------------------------------------
// eia3 mac package
// widths, types and helpers shared by the 128-eia3 mac accumulator
// ----------------------------------------------------------------------------
package eia3mac_pkg;

    localparam int WORD_BITS = 32;
    localparam int TAIL_BITS = 64;
    localparam int LEN_W     = 16;
    localparam int IDX_W     = 12;
    localparam int OFF_W     = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [IDX_W-1:0]     idx_t;

    typedef struct packed {
        logic active;
        idx_t word_idx;
        len_t len;
    } win_ctrl_t;

    // index of the word that closes the message
    function automatic idx_t last_index(input len_t len);
        logic [LEN_W:0] sum;
        sum = {1'b0, len} + (LEN_W+1)'(TAIL_BITS + WORD_BITS - 1);
        return sum[LEN_W:OFF_W] - idx_t'(1);
    endfunction

endpackage

// ===== sv/eia3mac_window_xor.sv =====
// ----------------------------------------------------------------------------
// eia3 mac window xor
// xor of the keystream windows selected by one message word and the length
// ----------------------------------------------------------------------------
module eia3mac_window_xor (
    input  eia3mac_pkg::word_t     key_hi,
    input  eia3mac_pkg::word_t     key_lo,
    input  eia3mac_pkg::word_t     msg_word,
    input  eia3mac_pkg::win_ctrl_t ctrl,
    output eia3mac_pkg::word_t     win_xor
);
    import eia3mac_pkg::*;

    logic [2*WORD_BITS-1:0]    win_cat;
    idx_t                      cur_idx;
    idx_t                      len_word;
    logic [OFF_W-1:0]          len_off;
    logic                      before_len;
    logic                      at_len;
    logic                      bit_on;
    logic                      len_on;
    word_t                     acc;

    always_comb begin
        win_cat    = {key_hi, key_lo};
        cur_idx    = ctrl.word_idx - idx_t'(1);
        len_word   = idx_t'(ctrl.len[LEN_W-1:OFF_W]);
        len_off    = ctrl.len[OFF_W-1:0];
        before_len = cur_idx < len_word;
        at_len     = cur_idx == len_word;
        acc        = '0;
        bit_on     = 1'b0;
        len_on     = 1'b0;
        for (int b = 0; b < WORD_BITS; b++) begin
            bit_on = msg_word[WORD_BITS-1-b] &&
                     (before_len || (at_len && (OFF_W'(b) < len_off)));
            len_on = at_len && (OFF_W'(b) == len_off);
            if (ctrl.active && (bit_on || len_on)) begin
                acc = acc ^ win_cat[2*WORD_BITS-1-b -: WORD_BITS];
            end
        end
        win_xor = acc;
    end

endmodule

// ===== sv/eia3_mac_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// eia3 mac accumulator core
// 128-eia3 universal-hash mac over streamed keystream and message words
// ----------------------------------------------------------------------------
//  channel  | ports                          | request
//  s        | s_valid s_ready                | key_word, msg_word
//  m        | m_valid m_ready                | mac
//  cfg      | cfg_wr_en                      | msg_length_bits
//
//  one request per cycle unless stalled; a request is held in the input
//  register, then updates the accumulator or loads the mac register
//  a request that closes a message waits in the input register while an
//  earlier mac is still unread; other requests wait only behind such a request
//  aresetn clears the valid flags, the running state and the length register
// ----------------------------------------------------------------------------
module eia3_mac_accumulator_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  eia3mac_pkg::len_t   cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  eia3mac_pkg::word_t  s_key_word,
    input  eia3mac_pkg::word_t  s_msg_word,
    output logic                m_valid,
    input  logic                m_ready,
    output eia3mac_pkg::word_t  m_mac
);
    import eia3mac_pkg::*;

    len_t      len_reg;
    logic      in_valid_reg;
    word_t     in_key_reg;
    word_t     in_msg_reg;
    word_t     prev_key_reg;
    word_t     prev_msg_reg;
    idx_t      word_idx_reg;
    word_t     accum_reg;
    logic      out_valid_reg;
    word_t     mac_reg;

    win_ctrl_t win_ctrl;
    word_t     win_xor;
    word_t     accum_next;
    logic      emit;
    logic      proceed;

    assign win_ctrl.active   = word_idx_reg != '0;
    assign win_ctrl.word_idx = word_idx_reg;
    assign win_ctrl.len      = len_reg;

    eia3mac_window_xor u_window (
        .key_hi   (prev_key_reg),
        .key_lo   (in_key_reg),
        .msg_word (prev_msg_reg),
        .ctrl     (win_ctrl),
        .win_xor  (win_xor)
    );

    assign accum_next = accum_reg ^ win_xor;
    assign emit       = word_idx_reg >= last_index(len_reg);
    assign proceed    = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || proceed;
    assign m_valid    = out_valid_reg;
    assign m_mac      = mac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cfg_wr_en) begin
            len_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_key_reg <= s_key_word;
            in_msg_reg <= s_msg_word;
        end
    end

    // running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_key_reg <= '0;
            prev_msg_reg <= '0;
            word_idx_reg <= '0;
            accum_reg    <= '0;
        end else if (proceed) begin
            if (emit) begin
                prev_key_reg <= '0;
                prev_msg_reg <= '0;
                word_idx_reg <= '0;
                accum_reg    <= '0;
            end else begin
                prev_key_reg <= in_key_reg;
                prev_msg_reg <= in_msg_reg;
                word_idx_reg <= word_idx_reg + idx_t'(1);
                accum_reg    <= accum_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proceed && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && emit) begin
            mac_reg <= accum_next ^ in_key_reg;
        end
    end

endmodule

// ===== sv/eia3mac_checker.sv =====
// ----------------------------------------------------------------------------
// eia3 mac checker
// port-level properties of the mac accumulator core, bound into the core
// ----------------------------------------------------------------------------
`include "eia3_mac_accumulator_core_macros.svh"

module eia3mac_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input eia3mac_pkg::word_t m_mac
);
    import eia3mac_pkg::*;

    // held result stays put
    `EIA3_ASSERT_NEXT(a_mac_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_mac), "mac dropped or changed while stalled")

    // no result right out of reset
    `EIA3_ASSERT_NEXT(a_reset_clear, aclk, 1'b1, !aresetn, !m_valid, "result valid after reset")

    // a new result must be preceded by an accepted request
    `EIA3_ASSERT_NOW(a_mac_source, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 2), "result without a request")

    // input side only waits on an unread result
    `EIA3_ASSERT_NOW(a_ready_free, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output")

endmodule

bind eia3_mac_accumulator_core eia3mac_checker u_eia3mac_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_mac   (m_mac)
);
